// ----- design/rational_arithmetic_unit_core_assert.svh -----
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Check that the right side holds in the cycle after the left side.
`define RAU_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ----- design/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;
    localparam int FIELD_BITS = 32;
    localparam int WIDE_BITS  = 64;
    localparam int CNT_BITS   = 7;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    // Modes from here up all compare.
    localparam logic [2:0] MODE_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMBINE, S_GCD, S_DIVN, S_DIVD, S_DONE
    } t_state;

    // Request and reply of the shared divider.
    typedef struct packed {
        logic                 start;
        logic [WIDE_BITS-1:0] dividend;
        logic [WIDE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [WIDE_BITS-1:0] quot;
        logic [WIDE_BITS-1:0] rem;
    } t_div_rsp;
endpackage

// ----- design/rau_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module rau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp o_rsp
);
    import rau_pkg::*;

    logic [WIDE_BITS-1:0] r_q, n_q, r_r, n_r, r_d;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_done, n_done;
    logic [WIDE_BITS:0]   w_sh, w_diff;

    always_comb begin
        w_sh   = {r_r, r_q[WIDE_BITS-1]};
        w_diff = w_sh - {1'b0, r_d};
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_q = i_req.dividend; n_r = '0; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[WIDE_BITS]) begin
                n_r = w_diff[WIDE_BITS-1:0];
                n_q = {r_q[WIDE_BITS-2:0], 1'b1};
            end else begin
                n_r = w_sh[WIDE_BITS-1:0];
                n_q = {r_q[WIDE_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(WIDE_BITS - 1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r;
        if (i_req.start) r_d <= i_req.divisor;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;
endmodule

// ----- design/rational_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// signed 32-bit fractions and reduce the result by the gcd.
// Channels: raise start with mode and operands while busy is low; the
// word is taken at that edge and busy rises the next cycle. The result
// word (o_res_num, o_res_den, o_order, o_status) shows for exactly one
// cycle with o_valid high; the receiver cannot hold it off.
// Order of work: a zero denominator goes straight from idle to the result;
// compare, divide by zero and a zero result end after the combine state.
// Arithmetic runs the multiply states S_MUL1 to S_MUL3 and a combine
// state, then one division per Euclid step of the gcd, then two more
// divisions by the gcd. All divisions run on the single shared
// bit-serial divider.
// busy stays high through the o_valid cycle, so the next word can be taken
// in the cycle after the result. One word is in flight at a time.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any word in flight; no result is given for it.
module rational_arithmetic_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic        o_valid,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_order,
    output logic [1:0]  o_status
);
    import rau_pkg::*;

    t_state r_state, n_state;
    t_div_req w_req;
    t_div_rsp w_rsp;

    // Operands held as sign + magnitude after denominator normalization.
    logic [2:0]  r_mode;
    logic        r_sa, r_sb;
    logic [32:0] r_am, r_bm, r_ad, r_bd;
    logic [63:0] r_p, r_q, r_dm, r_nm, r_y, r_g;
    logic        r_neg;
    logic [63:0] w_mul;
    logic [32:0] w_ma, w_mb;
    logic [1:0]  r_idx;
    logic        r_valid;
    logic [31:0] r_rnum;
    logic [30:0] r_rden;
    logic [1:0]  r_ord, r_st;

    logic signed [32:0] w_an, w_bn, w_ad, w_bd;
    logic [63:0] w_lim;
    logic        w_ovf;

    // Combine stage: signed numerator, denominator and compare outcome.
    logic        w_sb, w_lneg, w_rneg, w_neg, w_divz, w_go;
    logic [63:0] w_nm, w_dm;
    logic [1:0]  w_ord;
    logic        w_take, w_zden;

    assign w_take = start && !busy;
    assign w_zden = (i_a_den == 32'sd0) || (i_b_den == 32'sd0);

    assign w_an = i_a_den[31] ? -33'(i_a_num) : 33'(i_a_num);
    assign w_ad = i_a_den[31] ? -33'(i_a_den) : 33'(i_a_den);
    assign w_bn = i_b_den[31] ? -33'(i_b_num) : 33'(i_b_num);
    assign w_bd = i_b_den[31] ? -33'(i_b_den) : 33'(i_b_den);

    // One 33x33 magnitude multiplier, shared over the states S_MUL1, S_MUL2 and S_MUL3.
    always_comb begin
        w_ma = r_am; w_mb = r_bd;
        case (r_idx)
            2'd0: begin
                w_ma = r_am;
                w_mb = (r_mode == MODE_MUL) ? r_bm : r_bd;
            end
            2'd1: begin
                w_ma = (r_mode == MODE_DIV) ? r_ad : r_bm;
                w_mb = (r_mode == MODE_DIV) ? r_bm : r_ad;
            end
            2'd2: begin
                w_ma = r_ad; w_mb = r_bd;
            end
            default: begin
                w_ma = r_am; w_mb = r_bd;
            end
        endcase
        w_mul = 64'(w_ma) * 64'(w_mb);
    end

    // Apply the signs and pick numerator and denominator; divide takes b's
    // magnitude into the denominator.
    always_comb begin
        w_sb  = (r_mode == MODE_SUB) ? ~r_sb : r_sb;
        w_nm  = r_p;
        w_dm  = r_dm;
        w_neg = r_sa ^ r_sb;
        if (r_mode <= MODE_SUB) begin
            if (r_sa == w_sb) begin
                w_nm = r_p + r_q; w_neg = r_sa;
            end else if (r_p >= r_q) begin
                w_nm = r_p - r_q; w_neg = r_sa;
            end else begin
                w_nm = r_q - r_p; w_neg = w_sb;
            end
        end else if (r_mode == MODE_DIV) begin
            w_dm = r_q;
        end
        // l = a*bd signed, r = b*ad signed
        w_lneg = r_sa && r_p != 64'd0;
        w_rneg = r_sb && r_q != 64'd0;
        if (w_lneg != w_rneg) w_ord = w_lneg ? ORD_LT : ORD_GT;
        else if (r_p == r_q) w_ord = ORD_EQ;
        else w_ord = ((r_p < r_q) ^ w_lneg) ? ORD_LT : ORD_GT;
        w_divz = (r_mode == MODE_DIV) && (r_bm == 33'd0);
        w_go   = (r_mode < MODE_CMP) && !w_divz && (w_nm != 64'd0);
    end

    assign w_lim = 64'd1 << (FIELD_BITS - 1);
    assign w_ovf = (w_rsp.quot > w_lim - 64'd1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_take) n_state = w_zden ? S_DONE : S_MUL1;
            S_MUL1:    n_state = S_MUL2;
            S_MUL2:    n_state = S_MUL3;
            S_MUL3:    n_state = S_COMBINE;
            S_COMBINE: n_state = w_go ? S_GCD : S_DONE;
            S_GCD:     if (w_rsp.done && w_rsp.rem == 64'd0) n_state = S_DIVN;
            S_DIVN:    if (w_rsp.done) n_state = S_DIVD;
            S_DIVD:    if (w_rsp.done) n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_req.start = 1'b0; w_req.dividend = r_nm; w_req.divisor = r_y;
        case (r_state)
            S_COMBINE: if (w_go) begin
                // Seed the first gcd step.
                w_req.start = 1'b1; w_req.dividend = w_nm; w_req.divisor = w_dm;
            end
            S_GCD: begin
                if (w_rsp.done && w_rsp.rem != 64'd0) begin
                    w_req.start = 1'b1; w_req.dividend = r_y; w_req.divisor = w_rsp.rem;
                end else if (w_rsp.done) begin
                    w_req.start = 1'b1; w_req.dividend = r_nm; w_req.divisor = r_y;
                end
            end
            S_DIVN: if (w_rsp.done) begin
                w_req.start = 1'b1; w_req.dividend = r_dm; w_req.divisor = r_g;
            end
            default: ;
        endcase
    end

    rau_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: if (w_take) begin
                    // Hold normalized operands; catch zero denominators early.
                    r_mode <= i_mode;
                    r_sa <= w_an[32]; r_sb <= w_bn[32];
                    r_am <= w_an[32] ? 33'(-w_an) : 33'(w_an);
                    r_bm <= w_bn[32] ? 33'(-w_bn) : 33'(w_bn);
                    r_ad <= 33'(w_ad); r_bd <= 33'(w_bd);
                    r_idx <= 2'd0;
                    if (w_zden) begin
                        r_rnum <= '0; r_rden <= '0; r_ord <= ORD_LT; r_st <= ST_ZDEN;
                    end
                end
                S_MUL1: begin r_p <= w_mul; r_idx <= 2'd1; end
                S_MUL2: begin r_q <= w_mul; r_idx <= 2'd2; end
                S_MUL3: r_dm <= w_mul;
                S_COMBINE: begin
                    r_nm <= w_nm; r_dm <= w_dm; r_neg <= w_neg; r_y <= w_dm;
                    r_rnum <= '0;
                    r_ord  <= (r_mode >= MODE_CMP) ? w_ord : ORD_LT;
                    r_st   <= w_divz ? ST_DIVZ : ST_OK;
                    // Zero comes out as 0/1.
                    r_rden <= (r_mode < MODE_CMP && !w_divz && w_nm == 64'd0) ?
                              31'd1 : 31'd0;
                end
                S_GCD: if (w_rsp.done) begin
                    if (w_rsp.rem != 64'd0) r_y <= w_rsp.rem;
                    else r_g <= r_y;
                end
                S_DIVN: if (w_rsp.done) begin
                    r_nm <= w_rsp.quot;
                end
                S_DIVD: if (w_rsp.done) begin
                    if (w_ovf || (r_neg ? r_nm > w_lim : r_nm > w_lim - 64'd1)) begin
                        r_st <= ST_OVF;
                    end else begin
                        r_rnum <= r_neg ? 32'(64'd0 - r_nm) : r_nm[31:0];
                        r_rden <= w_rsp.quot[30:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE) || r_valid;
    assign o_valid   = r_valid;
    assign o_res_num = r_rnum;
    assign o_res_den = r_rden;
    assign o_order   = r_ord;
    assign o_status  = r_st;
endmodule

// ----- design/rau_checker.sv -----
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_core_assert.svh"
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [30:0] o_res_den,
    input logic [1:0]  o_order,
    input logic [1:0]  o_status
);
    import rau_pkg::*;

    `RAU_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    `RAU_ASSERT_NEXT(a_one_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `RAU_ASSERT_IMP(a_err_den, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_res_den == 31'd0)
    `RAU_ASSERT_IMP(a_ord_code, i_clk, i_rst_n, o_valid, o_order != 2'd3)
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid),
    .o_res_den(o_res_den), .o_order(o_order), .o_status(o_status)
);

// ----- tb/rational_arithmetic_unit_core_test.sv -----
`timescale 1ns / 1ps
module rational_arithmetic_unit_core_test;
    import rau_pkg::*;

    localparam int N_RANDOM   = 400;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_word;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_mode = '0;
    logic signed [31:0] i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic o_valid;
    logic signed [31:0] o_res_num;
    logic [30:0] o_res_den;
    logic [1:0] o_order, o_status;

    t_word   pending_words[$];
    t_answer expected_answers[$];
    int sent_cnt = 0, taken_cnt = 0, answer_cnt = 0, errors = 0, idle_cycles = 0;
    int gap_left = 0;
    int total_words = 0;
    int status_seen[4] = '{default: 0};

    rational_arithmetic_unit_core uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Compute the reduced fraction, compare outcome and status for one word.
    function automatic t_answer reduce_fraction(t_word w);
        t_answer r;
        longint signed an, ad, bn, bd, l, rr;
        longint unsigned p, q, nm, dm, g, x, y, t, lim;
        bit neg, sa, sb;
        r = '0;
        an = longint'(w.a_num); ad = longint'(w.a_den);
        bn = longint'(w.b_num); bd = longint'(w.b_den);
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZDEN;
            return r;
        end
        // Move the sign of each denominator into its numerator.
        if (ad < 0) begin an = -an; ad = -ad; end
        if (bd < 0) begin bn = -bn; bd = -bd; end
        if (w.mode >= MODE_CMP) begin
            l = an * bd;
            rr = bn * ad;
            r.order = (l < rr) ? ORD_LT : ((l > rr) ? ORD_GT : ORD_EQ);
            r.status = ST_OK;
            return r;
        end
        sa = an < 0;
        sb = bn < 0;
        if (w.mode == MODE_SUB) sb = !sb;
        if (w.mode == MODE_ADD || w.mode == MODE_SUB) begin
            p = longint'(an < 0 ? -an : an) * bd;
            q = longint'(bn < 0 ? -bn : bn) * ad;
            dm = ad * bd;
            if (sa == sb) begin
                nm = p + q; neg = sa;
            end else if (p >= q) begin
                nm = p - q; neg = sa;
            end else begin
                nm = q - p; neg = sb;
            end
        end else if (w.mode == MODE_MUL) begin
            nm = longint'(an < 0 ? -an : an) * longint'(bn < 0 ? -bn : bn);
            dm = ad * bd;
            neg = sa != sb;
        end else begin
            if (bn == 0) begin
                r.status = ST_DIVZ;
                return r;
            end
            nm = longint'(an < 0 ? -an : an) * bd;
            dm = ad * longint'(bn < 0 ? -bn : bn);
            neg = sa != sb;
        end
        // Zero comes out as 0/1.
        if (nm == 0) begin
            r.den = 31'd1;
            return r;
        end
        x = nm; y = dm;
        while (y != 0) begin
            t = x % y; x = y; y = t;
        end
        g = x;
        nm = nm / g;
        dm = dm / g;
        lim = 64'd1 << 31;
        if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
            r.status = ST_OVF;
            return r;
        end
        r.num = 32'(neg ? 64'd0 - nm : nm);
        r.den = dm[30:0];
        return r;
    endfunction

    // Mostly small values so many results reduce and fit; some full range.
    function automatic logic signed [31:0] pick_value(bit is_den);
        int r;
        logic signed [31:0] v;
        r = $urandom_range(0, 9);
        if (r <= 5) begin
            v = $urandom_range(0, 2000) - 1000;
            if (is_den && v == 0) v = 1;
        end else if (r <= 7) begin
            v = $urandom;
        end else if (r == 8) begin
            v = 32'($signed(16'($urandom)));
        end else begin
            case ($urandom_range(0, 4))
                0: v = 32'sd0;
                1: v = 32'sd1;
                2: v = -32'sd1;
                3: v = 32'h7FFF_FFFF;
                default: v = 32'h8000_0000;
            endcase
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    function automatic t_word make_word(logic [2:0] m, int an, int ad, int bn, int bd);
        t_word w;
        w.mode = m; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
        return w;
    endfunction

    // Drive at the falling edge; hold start until the word is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && taken_cnt != sent_cnt) begin
                // hold
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (pending_words.size() > 0) begin
                t_word w;
                w = pending_words.pop_front();
                i_mode <= w.mode;
                i_a_num <= w.a_num;
                i_a_den <= w.a_den;
                i_b_num <= w.b_num;
                i_b_den <= w.b_den;
                start <= 1'b1;
                sent_cnt++;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Sample at the rising edge: check the result word, then log any new word.
    always @(posedge i_clk) begin
        t_answer exp_a;
        t_word w;
        if (i_rst_n) begin
            if (o_valid) begin
                answer_cnt++;
                if (expected_answers.size() == 0) begin
                    $error("result with nothing expected: num %0d den %0d", o_res_num,
                           o_res_den);
                    errors++;
                end else begin
                    exp_a = expected_answers.pop_front();
                    status_seen[exp_a.status]++;
                    if (o_res_num !== exp_a.num) begin
                        $error("res_num expected %0d actual %0d", exp_a.num, o_res_num);
                        errors++;
                    end
                    if (o_res_den !== exp_a.den) begin
                        $error("res_den expected %0d actual %0d", exp_a.den, o_res_den);
                        errors++;
                    end
                    if (o_order !== exp_a.order) begin
                        $error("order expected %0d actual %0d", exp_a.order, o_order);
                        errors++;
                    end
                    if (o_status !== exp_a.status) begin
                        $error("status expected %0d actual %0d", exp_a.status, o_status);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                w = make_word(i_mode, i_a_num, i_a_den, i_b_num, i_b_den);
                expected_answers.push_back(reduce_fraction(w));
                taken_cnt++;
            end
            // Watchdog: count cycles where nothing moves.
            if ((start && !busy) || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("rational_arithmetic_unit_core_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_word w;
        int k;
        // Directed words: every mode, extremes, zero denominators, divide by zero.
        pending_words.push_back(make_word(MODE_ADD, 1, 2, 1, 3));
        pending_words.push_back(make_word(MODE_SUB, 1, 2, 1, 2));
        pending_words.push_back(make_word(MODE_MUL, -3, 4, 4, -6));
        pending_words.push_back(make_word(MODE_DIV, 5, 7, -10, 21));
        pending_words.push_back(make_word(MODE_CMP, 1, 3, 2, 6));
        pending_words.push_back(make_word(MODE_CMP, -1, 3, 1, 3));
        pending_words.push_back(make_word(MODE_CMP, 2, -3, -1, 3));
        pending_words.push_back(make_word(3'd5, 7, 2, 3, 1));
        pending_words.push_back(make_word(3'd6, 1, 1, 1, 1));
        pending_words.push_back(make_word(3'd7, -5, 1, 4, 1));
        pending_words.push_back(make_word(MODE_ADD, 1, 0, 1, 1));
        pending_words.push_back(make_word(MODE_DIV, 1, 1, 1, 0));
        pending_words.push_back(make_word(MODE_CMP, 1, 0, 1, 1));
        pending_words.push_back(make_word(MODE_DIV, 3, 1, 0, 5));
        pending_words.push_back(make_word(MODE_MUL, 0, 9, 5, 3));
        pending_words.push_back(make_word(MODE_ADD, 32'h7FFF_FFFF, 1, 1, 1));
        pending_words.push_back(make_word(MODE_SUB, 32'h8000_0000, 1, 1, 1));
        pending_words.push_back(make_word(MODE_MUL, 32'h8000_0000, 1, -1, 1));
        pending_words.push_back(make_word(MODE_MUL, 32'h8000_0000, -1, 1, 1));
        pending_words.push_back(make_word(MODE_DIV, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h8000_0000));
        pending_words.push_back(make_word(MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h8000_0000, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(MODE_CMP, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(MODE_SUB, -6, -4, 3, 2));
        for (k = 0; k < N_RANDOM; k++) begin
            w.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
            w.a_num = pick_value(1'b0);
            w.a_den = pick_value(1'b1);
            w.b_num = pick_value(1'b0);
            w.b_den = pick_value(1'b1);
            pending_words.push_back(w);
        end
        total_words = pending_words.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        wait (taken_cnt == total_words && expected_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words over all modes: %0d ok, %0d zero den, %0d div by zero,",
                 taken_cnt, status_seen[ST_OK], status_seen[ST_ZDEN], status_seen[ST_DIVZ]);
        $display("  %0d overflow; %0d results checked", status_seen[ST_OVF], answer_cnt);
        if (errors == 0 && expected_answers.size() == 0)
            $display("rational_arithmetic_unit_core_test: PASS");
        else
            $display("rational_arithmetic_unit_core_test: FAIL");
        $finish;
    end
endmodule
